@@ rtl/core/ate_pkg.sv @@
// ============================================================================
// ate_pkg - shared types and constants
// Item and result structs, configuration struct, sequencer states and
// fixed constants of the tempo estimator.
// ============================================================================
package ate_pkg;

    localparam int WINDOW_SAMPLES_DEF = 131072;
    localparam int QUEUE_DEPTH        = 4;

    localparam logic [11:0] BPM_SCALE = 12'd3840;
    localparam logic [17:0] LAG_CAP   = 18'd131072;
    localparam logic [15:0] BPM_MAX   = 16'hFFFF;

    localparam logic [17:0] SAMPLE_RATE_RST   = 18'd48000;
    localparam logic [16:0] MIN_LAG_RST       = 17'd14400;
    localparam logic [17:0] MAX_LAG_RST       = 18'd48000;
    localparam logic [7:0]  MEASURE_COUNT_RST = 8'd5;

    // register indexes on the configuration port
    localparam logic [1:0] REG_SAMPLE_RATE   = 2'd0;
    localparam logic [1:0] REG_MIN_LAG       = 2'd1;
    localparam logic [1:0] REG_MAX_LAG       = 2'd2;
    localparam logic [1:0] REG_MEASURE_COUNT = 2'd3;

    typedef struct packed {
        logic signed [15:0] sample;
        logic               last_sample;
    } t_item;

    typedef struct packed {
        logic [16:0] best_lag;
        logic [15:0] window_bpm;
        logic [15:0] average_bpm;
        logic        final_res;
    } t_res;

    typedef struct packed {
        logic [17:0] sample_rate;
        logic [16:0] min_lag;
        logic [17:0] max_lag;
        logic [7:0]  measure_count;
    } t_cfg;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SUM,
        S_MEAN,
        S_LAG,
        S_CORR,
        S_CMP,
        S_BPM_GO,
        S_BPM,
        S_TALLY,
        S_AVG,
        S_OUT
    } t_state;

endpackage

@@ rtl/core/ate_fifo.sv @@
// ============================================================================
// ate_fifo - small synchronous queue
// Decouples the sample intake and the result delivery from the back end.
// ============================================================================
module ate_fifo
    import ate_pkg::*;
#(
    parameter int WIDTH = 17,
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW:0]      r_wr;
    logic [PW:0]      r_rd;
    logic             do_push;
    logic             do_pop;

    assign o_empty = (r_wr == r_rd);
    assign o_full  = (r_wr[PW] != r_rd[PW]) && (r_wr[PW-1:0] == r_rd[PW-1:0]);
    assign o_data  = r_mem[r_rd[PW-1:0]];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    // advance pointers on each transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr <= '0;
            r_rd <= '0;
        end else begin
            if (do_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= r_rd + 1'b1;
            end
        end
    end

    // store entry
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr[PW-1:0]] <= i_data;
        end
    end

endmodule

@@ rtl/core/ate_div.sv @@
// ============================================================================
// ate_div - restoring divider
// Unsigned division, one quotient bit per cycle, shared by the mean, the
// tempo conversion and the average.
// ============================================================================
module ate_div
    import ate_pkg::*;
#(
    parameter int DVW = 36,
    parameter int DSW = 18
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic [DVW-1:0] i_dividend,
    input  logic [DSW-1:0] i_divisor,
    output logic           o_done,
    output logic [DVW-1:0] o_quo,
    output logic [DSW-1:0] o_rem
);

    localparam int CNW = $clog2(DVW + 1);

    logic [CNW-1:0] r_cnt;
    logic           r_busy;
    logic           r_done;
    logic [DVW-1:0] r_quo;
    logic [DSW-1:0] r_rem;
    logic [DSW-1:0] r_dsr;
    logic [DSW:0]   n_sh;
    logic           n_bit;
    logic [DSW:0]   n_diff;

    // trial subtract of the shifted remainder
    always_comb begin
        n_sh   = {r_rem, r_quo[DVW-1]};
        n_bit  = (n_sh >= {1'b0, r_dsr});
        n_diff = n_sh - {1'b0, r_dsr};
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNW'(DVW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dsr <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[DVW-2:0], n_bit};
            r_rem <= n_bit ? n_diff[DSW-1:0] : n_sh[DSW-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;
    assign o_rem  = r_rem;

endmodule

@@ rtl/core/ate_back.sv @@
// ============================================================================
// ate_back - window store and lag search engine
// Stores samples in the ring memory, and on a window end removes the mean,
// runs the autocorrelation lag by lag and converts the best lag to tempo.
// ============================================================================
module ate_back
    import ate_pkg::*;
#(
    parameter int WINDOW_SAMPLES = WINDOW_SAMPLES_DEF
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_cfg  i_cfg,
    input  logic  i_in_empty,
    input  t_item i_in_item,
    output logic  o_in_pop,
    input  logic  i_out_full,
    output logic  o_out_push,
    output t_res  o_res
);

    localparam int AW  = $clog2(WINDOW_SAMPLES);
    localparam int NW  = $clog2(WINDOW_SAMPLES + 1);
    localparam int SW  = NW + 16;
    localparam int ACW = NW + 36;
    localparam int CW  = (NW > 18) ? NW : 18;
    localparam int DVW = (SW > 30) ? SW : 30;
    localparam int DSW = (NW > 18) ? NW : 18;
    localparam logic [NW:0] WIN = (NW + 1)'(WINDOW_SAMPLES);

    logic [15:0] r_mem [WINDOW_SAMPLES];

    t_state r_state;
    t_state n_state;

    logic [AW-1:0]          r_wp;
    logic [NW-1:0]          r_fill;
    logic [NW-1:0]          r_n;
    logic [AW-1:0]          r_start;
    logic [NW-1:0]          r_i;
    logic [NW-1:0]          r_cnt;
    logic                   r_v1;
    logic                   r_v2;
    logic signed [15:0]     r_qa;
    logic signed [15:0]     r_qb;
    logic signed [SW-1:0]   r_sum;
    logic signed [16:0]     r_mean;
    logic [16:0]            r_lag;
    logic                   r_first;
    logic [16:0]            r_best;
    logic signed [35:0]     r_prod;
    logic signed [ACW-1:0]  r_acc;
    logic signed [ACW-1:0]  r_bestval;
    logic [15:0]            r_bpm;
    logic [23:0]            r_tsum;
    logic [7:0]             r_wdone;
    logic                   r_fin;
    logic [15:0]            r_avg;
    logic                   r_meas;

    logic                   issue;
    logic [AW-1:0]          addr_a;
    logic [AW-1:0]          addr_b;
    logic [NW-1:0]          off_b;
    logic [AW-1:0]          wp_inc;
    logic [NW-1:0]          fill_inc;
    logic [NW:0]            start_t;
    logic [AW-1:0]          start_new;
    logic signed [17:0]     ca;
    logic signed [17:0]     cb;
    logic                   sum_neg;
    logic [SW-1:0]          sum_mag;
    logic [16:0]            mean_mag;
    logic [17:0]            nxt;
    logic [17:0]            bound;
    logic                   lag_past;
    logic                   brk;
    logic                   cont;
    logic                   take;
    logic [16:0]            best_new;
    logic [29:0]            bpm_num;
    logic [23:0]            tsum_new;
    logic [7:0]             wd_new;
    logic                   fin_new;
    logic                   div_start;
    logic [DVW-1:0]         div_dvd;
    logic [DSW-1:0]         div_dsr;
    logic                   div_done;
    logic [DVW-1:0]         div_quo;
    logic [DSW-1:0]         div_rem;

    // ring address of window element
    function automatic logic [AW-1:0] ring_addr(input logic [AW-1:0] base,
                                                input logic [NW-1:0] off);
        logic [NW:0] s;
        s = (NW + 1)'(base) + (NW + 1)'(off);
        if (s >= WIN) begin
            s = s - WIN;
        end
        return s[AW-1:0];
    endfunction

    // intake arithmetic
    always_comb begin
        wp_inc   = (r_wp == AW'(WINDOW_SAMPLES - 1)) ? '0 : r_wp + 1'b1;
        fill_inc = ((NW + 1)'(r_fill) < WIN) ? r_fill + 1'b1 : r_fill;
        start_t  = (NW + 1)'(wp_inc) + WIN - (NW + 1)'(fill_inc);
        if (start_t >= WIN) begin
            start_t = start_t - WIN;
        end
        start_new = start_t[AW-1:0];
    end

    // read addresses and centered operands
    always_comb begin
        issue  = ((r_state == S_SUM) || (r_state == S_CORR)) && (r_i < r_cnt);
        off_b  = r_i + NW'(r_lag);
        addr_a = ring_addr(r_start, r_i);
        addr_b = ring_addr(r_start, off_b);
        ca     = 18'(r_qa) - 18'(r_mean);
        cb     = 18'(r_qb) - 18'(r_mean);
    end

    // mean from the divider, floored
    always_comb begin
        sum_neg  = r_sum[SW-1];
        sum_mag  = sum_neg ? SW'(-r_sum) : SW'(r_sum);
        mean_mag = div_quo[16:0] + 17'((sum_neg && (div_rem != '0)) ? 1 : 0);
    end

    // lag search step
    always_comb begin
        bound    = (i_cfg.max_lag > LAG_CAP) ? LAG_CAP : i_cfg.max_lag;
        nxt      = r_first ? (18'(i_cfg.min_lag) + 18'd1) : (18'(r_lag) + 18'd1);
        lag_past = (CW'(r_lag) >= CW'(r_n));
        brk      = !r_first && lag_past;
        cont     = !brk && (nxt < bound);
        take     = r_first || (r_acc > r_bestval);
        best_new = take ? r_lag : r_best;
    end

    // tempo bookkeeping
    always_comb begin
        bpm_num  = 30'(BPM_SCALE) * 30'(i_cfg.sample_rate);
        tsum_new = r_tsum + 24'(r_bpm);
        wd_new   = r_wdone + 8'd1;
        fin_new  = (wd_new >= i_cfg.measure_count);
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (!i_in_empty && r_meas && i_in_item.last_sample) begin
                    n_state = S_SUM;
                end
            end
            S_SUM: begin
                if (!issue && !r_v1) begin
                    n_state = S_MEAN;
                end
            end
            S_MEAN: begin
                if (div_done) begin
                    n_state = S_LAG;
                end
            end
            S_LAG: begin
                n_state = (CW'(r_lag) < CW'(r_n)) ? S_CORR : S_CMP;
            end
            S_CORR: begin
                if (!issue && !r_v1 && !r_v2) begin
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                n_state = cont ? S_LAG : S_BPM_GO;
            end
            S_BPM_GO: begin
                n_state = (r_best == '0) ? S_TALLY : S_BPM;
            end
            S_BPM: begin
                if (div_done) begin
                    n_state = S_TALLY;
                end
            end
            S_TALLY: begin
                n_state = (fin_new && (wd_new != '0)) ? S_AVG : S_OUT;
            end
            S_AVG: begin
                if (div_done) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (!i_out_full) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // handshakes and divider launch
    always_comb begin
        o_in_pop   = (r_state == S_IDLE) && !i_in_empty;
        o_out_push = (r_state == S_OUT) && !i_out_full;
        div_start  = 1'b0;
        div_dvd    = DVW'(sum_mag);
        div_dsr    = DSW'(r_n);
        unique case (r_state)
            S_SUM: begin
                div_start = !issue && !r_v1;
            end
            S_BPM_GO: begin
                div_start = (r_best != '0);
                div_dvd   = DVW'(bpm_num);
                div_dsr   = DSW'(r_best);
            end
            S_TALLY: begin
                div_start = fin_new && (wd_new != '0);
                div_dvd   = DVW'(tsum_new);
                div_dsr   = DSW'(wd_new);
            end
            default: begin
                div_start = 1'b0;
            end
        endcase
    end

    // state register and control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_wp    <= '0;
            r_fill  <= '0;
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
            r_tsum  <= '0;
            r_wdone <= '0;
            r_meas  <= 1'b1;
        end else begin
            r_state <= n_state;
            r_v1    <= issue;
            r_v2    <= (r_state == S_CORR) && r_v1;
            if (o_in_pop && r_meas) begin
                r_wp   <= wp_inc;
                r_fill <= fill_inc;
            end
            if (r_state == S_TALLY) begin
                r_tsum  <= tsum_new;
                r_wdone <= wd_new;
            end
            if (o_out_push && r_fin) begin
                r_meas <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_i <= r_i + 1'b1;
        end
        unique case (r_state)
            S_IDLE: begin
                r_n     <= fill_inc;
                r_cnt   <= fill_inc;
                r_start <= start_new;
                r_i     <= '0;
                r_sum   <= '0;
            end
            S_SUM: begin
                if (r_v1) begin
                    r_sum <= r_sum + SW'(r_qa);
                end
            end
            S_MEAN: begin
                r_mean  <= sum_neg ? -$signed(mean_mag) : $signed(mean_mag);
                r_lag   <= i_cfg.min_lag;
                r_first <= 1'b1;
            end
            S_LAG: begin
                r_acc <= '0;
                r_i   <= '0;
                r_cnt <= r_n - NW'(r_lag);
            end
            S_CORR: begin
                if (r_v1) begin
                    r_prod <= ca * cb;
                end
                if (r_v2) begin
                    r_acc <= r_acc + ACW'(r_prod);
                end
            end
            S_CMP: begin
                r_first <= 1'b0;
                r_best  <= best_new;
                if (take) begin
                    r_bestval <= r_acc;
                end
                r_lag <= nxt[16:0];
            end
            S_BPM_GO: begin
                r_bpm <= BPM_MAX;
            end
            S_BPM: begin
                r_bpm <= (div_quo > DVW'(BPM_MAX)) ? BPM_MAX : div_quo[15:0];
            end
            S_TALLY: begin
                r_fin <= fin_new;
                r_avg <= '0;
            end
            S_AVG: begin
                r_avg <= (div_quo > DVW'(BPM_MAX)) ? BPM_MAX : div_quo[15:0];
            end
            default: begin
            end
        endcase
    end

    // ring memory: one write port, two registered read ports
    always_ff @(posedge i_clk) begin
        if (o_in_pop && r_meas) begin
            r_mem[r_wp] <= i_in_item.sample;
        end
        r_qa <= r_mem[addr_a];
        r_qb <= r_mem[addr_b];
    end

    ate_div #(
        .DVW (DVW),
        .DSW (DSW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dvd),
        .i_divisor  (div_dsr),
        .o_done     (div_done),
        .o_quo      (div_quo),
        .o_rem      (div_rem)
    );

    assign o_res.best_lag    = r_best;
    assign o_res.window_bpm  = r_bpm;
    assign o_res.average_bpm = r_avg;
    assign o_res.final_res   = r_fin;

endmodule

@@ rtl/core/autocorrelation_tempo_estimator.sv @@
// ============================================================================
// autocorrelation_tempo_estimator - tempo estimate from audio autocorrelation
// Top level: configuration registers, intake queue, search engine and
// result queue.
// ============================================================================
// Samples are taken into a four-entry queue and written to the ring store
// one per cycle while the engine is idle. A sample flagged last starts the
// search, which occupies the engine: a sum over the n stored samples for
// the mean, one divider pass, then for every searched lag L below the
// window length n the sum of (n - L) products, the two-port ring memory
// delivering one product per cycle, and only a compare for a lag at or
// past n; further divider passes finish the tempo and, on the final
// window, the average. Samples keep queueing meanwhile and are taken at
// one per cycle once the search is done. The result waits in a four-entry
// queue. After the final result the block ignores all input until reset.
// The ring store is not cleared at reset.
module autocorrelation_tempo_estimator
    import ate_pkg::*;
#(
    parameter int WINDOW_SAMPLES = WINDOW_SAMPLES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    input  t_item       i_item,
    output logic        o_full,
    input  logic        i_pop,
    output t_res        o_res,
    output logic        o_empty,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    t_cfg  r_cfg;
    logic  cfg_we;
    logic  in_empty;
    t_item in_item;
    logic  in_pop;
    logic  out_full;
    logic  out_push;
    t_res  res;

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && pready;

    // configuration write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sample_rate   <= SAMPLE_RATE_RST;
            r_cfg.min_lag       <= MIN_LAG_RST;
            r_cfg.max_lag       <= MAX_LAG_RST;
            r_cfg.measure_count <= MEASURE_COUNT_RST;
        end else if (cfg_we) begin
            unique case (paddr[3:2])
                REG_SAMPLE_RATE:   r_cfg.sample_rate   <= pwdata[17:0];
                REG_MIN_LAG:       r_cfg.min_lag       <= pwdata[16:0];
                REG_MAX_LAG:       r_cfg.max_lag       <= pwdata[17:0];
                REG_MEASURE_COUNT: r_cfg.measure_count <= pwdata[7:0];
                default: begin
                end
            endcase
        end
    end

    // configuration read
    always_comb begin
        unique case (paddr[3:2])
            REG_SAMPLE_RATE:   prdata = 32'(r_cfg.sample_rate);
            REG_MIN_LAG:       prdata = 32'(r_cfg.min_lag);
            REG_MAX_LAG:       prdata = 32'(r_cfg.max_lag);
            REG_MEASURE_COUNT: prdata = 32'(r_cfg.measure_count);
            default:           prdata = '0;
        endcase
    end

    ate_fifo #(
        .WIDTH ($bits(t_item)),
        .DEPTH (QUEUE_DEPTH)
    ) u_in_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push),
        .i_data  (i_item),
        .o_full  (o_full),
        .i_pop   (in_pop),
        .o_data  (in_item),
        .o_empty (in_empty)
    );

    ate_back #(
        .WINDOW_SAMPLES (WINDOW_SAMPLES)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_in_empty (in_empty),
        .i_in_item  (in_item),
        .o_in_pop   (in_pop),
        .i_out_full (out_full),
        .o_out_push (out_push),
        .o_res      (res)
    );

    ate_fifo #(
        .WIDTH ($bits(t_res)),
        .DEPTH (QUEUE_DEPTH)
    ) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (out_push),
        .i_data  (res),
        .o_full  (out_full),
        .i_pop   (i_pop),
        .o_data  (o_res),
        .o_empty (o_empty)
    );

endmodule

@@ rtl/core/ate_chk.sv @@
// ============================================================================
// ate_chk - port-level checks
// Watches the result side of the tempo estimator over time.
// ============================================================================
module ate_chk
    import ate_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic i_pop,
    input logic o_empty,
    input t_res o_res
);

    // hold a waiting result until its transfer
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && !i_pop) |=> (!o_empty && $stable(o_res)))
        else $error("waiting result changed before transfer");

    // average only on the final result
    a_avg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && !o_res.final_res) |-> (o_res.average_bpm == '0))
        else $error("average shown on a non-final result");

    // zero lag saturates the tempo
    a_lag0: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && (o_res.best_lag == '0)) |-> (o_res.window_bpm == BPM_MAX))
        else $error("zero lag without saturated tempo");

    // nothing follows the final result
    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && o_res.final_res && i_pop) |=> o_empty)
        else $error("result after the final one");

endmodule

bind autocorrelation_tempo_estimator ate_chk u_chk (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_pop   (i_pop),
    .o_empty (o_empty),
    .o_res   (o_res)
);

@@ tb/autocorrelation_tempo_estimator_tb.sv @@
`timescale 1ns / 1ps
// ============================================================================
// autocorrelation_tempo_estimator_tb - self-checking bench for the estimator
// Drives audio samples through the push/full side and pops results. A
// scoreboard predicts the lag, tempo and average of each window. The run
// walks a directed table, then random windows under several register
// settings and idle patterns, then a final window and ignored input.
// ============================================================================
module autocorrelation_tempo_estimator_tb;
    import ate_pkg::*;

    localparam int RING_SIZE = 131072;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_push;
    t_item       i_item;
    logic        o_full;
    logic        i_pop;
    t_res        o_res;
    logic        o_empty;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    autocorrelation_tempo_estimator dut (.*);

    // directed table row
    typedef struct {
        logic signed [15:0] sample;
        logic               last;
        logic               typed;
        t_res               res;
    } t_row;

    // scoreboard state
    t_res               tempo_q[$];
    logic signed [15:0] audio_hist[$];
    longint             centered[];
    logic [17:0]        cur_rate;
    logic [16:0]        cur_min_lag;
    logic [17:0]        cur_max_lag;
    logic [7:0]         cur_measures;
    logic [23:0]        bpm_sum;
    logic [7:0]         windows_seen;
    logic               still_measuring;

    int errors;
    int items_sent;
    int results_checked;
    int idle_pct;
    int stall_pct;
    int hold_req;
    int hold_left;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // watchdog
    initial begin
        #60ms;
        $display("autocorrelation_tempo_estimator test failed");
        $finish;
    end

    function automatic longint lag_product(int unsigned lag, int unsigned n);
        longint acc;
        acc = 0;
        if (lag >= n) return 0;
        for (int unsigned i = 0; i + lag < n; i++) acc += centered[i] * centered[i + lag];
        return acc;
    endfunction

    // predict the effect of one accepted sample
    function automatic void track_sample(t_item it);
        int unsigned n;
        int unsigned bound;
        int unsigned best;
        longint      sum;
        longint      mean;
        longint      best_val;
        longint      v;
        longint      bpm;
        int unsigned avg;
        t_res        r;
        if (!still_measuring) return;
        audio_hist.insert(audio_hist.size(), it.sample);
        if (audio_hist.size() > RING_SIZE) void'(audio_hist.pop_front());
        if (!it.last_sample) return;
        n = audio_hist.size();
        centered = new[n];
        sum = 0;
        for (int unsigned i = 0; i < n; i++) begin
            centered[i] = longint'(audio_hist[i]);
            sum += centered[i];
        end
        // floor of the mean, toward minus infinity
        if (sum >= 0) mean = sum / n;
        else mean = -((-sum + n - 1) / n);
        for (int unsigned i = 0; i < n; i++) centered[i] -= mean;
        bound = (cur_max_lag > LAG_CAP) ? LAG_CAP : cur_max_lag;
        best = cur_min_lag;
        best_val = lag_product(cur_min_lag, n);
        for (int unsigned lag = cur_min_lag + 1; lag < bound; lag++) begin
            v = lag_product(lag, n);
            if (v > best_val) begin
                best_val = v;
                best = lag;
            end
            if (lag >= n) break;
        end
        if (best == 0) bpm = 65535;
        else bpm = (longint'(BPM_SCALE) * cur_rate) / best;
        if (bpm > 65535) bpm = 65535;
        bpm_sum = bpm_sum + 24'(bpm);
        windows_seen = windows_seen + 8'd1;
        r.best_lag = 17'(best);
        r.window_bpm = 16'(bpm);
        r.average_bpm = '0;
        r.final_res = (windows_seen >= cur_measures);
        if (r.final_res) begin
            avg = (windows_seen != 0) ? bpm_sum / windows_seen : 0;
            if (avg > 65535) avg = 65535;
            r.average_bpm = 16'(avg);
            still_measuring = 1'b0;
        end
        tempo_q.insert(tempo_q.size(), r);
    endfunction

    // offer one sample; returns after the transfer
    task automatic push_sample(logic signed [15:0] s, logic last);
        t_item it;
        while ($urandom_range(99) < idle_pct) begin
            i_push <= 1'b0;
            @(negedge i_clk);
        end
        it.sample = s;
        it.last_sample = last;
        i_push <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (o_full);
        track_sample(it);
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic go_quiet();
        i_push <= 1'b0;
        while (tempo_q.size() != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic reg_write(logic [1:0] idx, logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        case (idx)
            REG_SAMPLE_RATE:   cur_rate = value[17:0];
            REG_MIN_LAG:       cur_min_lag = value[16:0];
            REG_MAX_LAG:       cur_max_lag = value[17:0];
            REG_MEASURE_COUNT: cur_measures = value[7:0];
        endcase
    endtask

    task automatic set_regs(int rate, int lo, int hi, int count);
        reg_write(REG_SAMPLE_RATE, rate);
        reg_write(REG_MIN_LAG, lo);
        reg_write(REG_MAX_LAG, hi);
        reg_write(REG_MEASURE_COUNT, count);
    endtask

    task automatic random_samples(int count, int last_pct);
        logic signed [15:0] s;
        for (int k = 0; k < count; k++) begin
            case ($urandom_range(3))
                0: s = 16'($urandom);
                1: s = $urandom_range(1) ? 16'sh7FFF : -16'sh8000;
                default: s = 16'(int'($urandom_range(4000)) - 2000);
            endcase
            push_sample(s, $urandom_range(99) < last_pct);
        end
    endtask

    // result side: stall at random, hold off on request
    initial begin
        i_pop = 1'b0;
        hold_left = 0;
        forever begin
            @(negedge i_clk);
            if (hold_req > 0) begin
                hold_left = hold_req;
                hold_req = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_pop <= 1'b0;
            end else begin
                i_pop <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    // check each popped result against the oldest prediction
    always @(posedge i_clk) begin
        t_res want;
        if (i_rst_n && i_pop && !o_empty) begin
            if (tempo_q.size() == 0) begin
                $display("%0t: unexpected result %p", $realtime, o_res);
                errors++;
            end else begin
                want = tempo_q.pop_front();
                results_checked++;
                if (o_res.best_lag !== want.best_lag) begin
                    $display("%0t: best_lag exp %0d got %0d", $realtime,
                             want.best_lag, o_res.best_lag);
                    errors++;
                end
                if (o_res.window_bpm !== want.window_bpm) begin
                    $display("%0t: window_bpm exp %0d got %0d", $realtime,
                             want.window_bpm, o_res.window_bpm);
                    errors++;
                end
                if (o_res.average_bpm !== want.average_bpm) begin
                    $display("%0t: average_bpm exp %0d got %0d", $realtime,
                             want.average_bpm, o_res.average_bpm);
                    errors++;
                end
                if (o_res.final_res !== want.final_res) begin
                    $display("%0t: final_res exp %0b got %0b", $realtime,
                             want.final_res, o_res.final_res);
                    errors++;
                end
            end
        end
    end

    initial begin
        t_row rows[$];
        t_res dflt;
        int   waited;

        errors = 0;
        items_sent = 0;
        results_checked = 0;
        idle_pct = 0;
        stall_pct = 0;
        hold_req = 0;
        i_rst_n = 1'b0;
        i_push = 1'b0;
        i_item = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        cur_rate = SAMPLE_RATE_RST;
        cur_min_lag = MIN_LAG_RST;
        cur_max_lag = MAX_LAG_RST;
        cur_measures = MEASURE_COUNT_RST;
        bpm_sum = '0;
        windows_seen = '0;
        still_measuring = 1'b1;

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // keep measuring until the final phase; other registers stay at reset for the directed table
        reg_write(REG_MEASURE_COUNT, 255);

        // with reset lags the window is far shorter than min_lag: lag 14400
        dflt.best_lag = 17'd14400;
        dflt.window_bpm = 16'd12800;
        dflt.average_bpm = '0;
        dflt.final_res = 1'b0;
        rows = '{
            '{16'sd0,      1'b1, 1'b1, dflt},
            '{16'sh7FFF,   1'b0, 1'b0, dflt},
            '{-16'sh8000,  1'b0, 1'b0, dflt},
            '{16'sh7FFF,   1'b1, 1'b1, dflt},
            '{-16'sh8000,  1'b0, 1'b0, dflt},
            '{-16'sh8000,  1'b0, 1'b0, dflt},
            '{-16'sd1,     1'b1, 1'b1, dflt},
            '{16'sd1,      1'b0, 1'b0, dflt},
            '{16'sh5555,   1'b0, 1'b0, dflt},
            '{-16'sh5556,  1'b1, 1'b1, dflt},
            '{16'sd100,    1'b0, 1'b0, dflt},
            '{-16'sd100,   1'b1, 1'b1, dflt}
        };
        foreach (rows[i]) begin
            push_sample(rows[i].sample, rows[i].last);
            if (rows[i].typed && tempo_q.size() != 0 && tempo_q[$] != rows[i].res) begin
                $display("%0t: row %0d predicted %p, table says %p", $realtime, i,
                         tempo_q[$], rows[i].res);
                errors++;
            end
        end
        go_quiet();

        // full lag range while the window is still short, bound at the cap
        set_regs(48000, 2, 131072, 255);
        random_samples(20, 20);
        go_quiet();

        // lag zero searched: always wins, tempo saturates
        idle_pct = 83;
        set_regs(0, 0, 20, 255);
        random_samples(20, 25);
        go_quiet();

        // zero sample rate gives zero tempo
        idle_pct = 0;
        stall_pct = 83;
        set_regs(0, 3, 18, 255);
        random_samples(20, 25);
        go_quiet();

        // single-lag range, largest rate
        idle_pct = 22;
        stall_pct = 22;
        set_regs(262143, 1, 2, 255);
        random_samples(20, 25);
        go_quiet();

        // lag beyond the window, largest bound clamped
        idle_pct = 0;
        stall_pct = 0;
        set_regs(8000, 131071, 262143, 255);
        random_samples(20, 20);
        go_quiet();

        // receiver holds off while every sample ends a window
        hold_req = 3000;
        for (int k = 0; k < 25; k++) push_sample(16'($urandom), 1'b1);
        go_quiet();

        // bulk of random windows over short lag ranges and all idle patterns
        for (int ph = 0; ph < 8; ph++) begin
            case (ph % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 83; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 83; end
                default: begin idle_pct = 22; stall_pct = 22; end
            endcase
            set_regs($urandom_range(192000, 8000), $urandom_range(8, 1),
                     $urandom_range(28, 10), 255);
            random_samples(18, 17);
            go_quiet();
        end

        // finish measuring on the next window, then input is ignored
        idle_pct = 0;
        stall_pct = 0;
        set_regs(192000, 1, 24, 1);
        random_samples(3, 0);
        push_sample(16'($urandom), 1'b1);
        for (int k = 0; k < 6; k++) push_sample(16'($urandom), k[0]);
        i_push <= 1'b0;

        waited = 0;
        while (tempo_q.size() != 0 && waited < 2000000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (2000) @(posedge i_clk);
        if (tempo_q.size() != 0) begin
            $display("%0t: %0d results never arrived", $realtime, tempo_q.size());
            errors++;
        end

        $display("Covered %0d samples in %0d windows; %0d results checked, %0d errors.",
                 items_sent, windows_seen, results_checked, errors);
        if (errors == 0) begin
            $display("autocorrelation_tempo_estimator test passed");
        end else begin
            $display("autocorrelation_tempo_estimator test failed");
        end
        $finish;
    end

endmodule

@@ files.f @@
rtl/core/ate_pkg.sv
rtl/core/ate_fifo.sv
rtl/core/ate_div.sv
rtl/core/ate_back.sv
rtl/core/autocorrelation_tempo_estimator.sv
rtl/core/ate_chk.sv
tb/autocorrelation_tempo_estimator_tb.sv
